// ===== hdl/priority_voice_channel_allocator_assert.svh =====
// Assertion macros for the channel allocator. Each one samples on the
// rising edge of the given clock and is switched off while reset is low.
`ifndef PRIORITY_VOICE_CHANNEL_ALLOCATOR_ASSERT_SVH
`define PRIORITY_VOICE_CHANNEL_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define PVCA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pvca assertion failed");
`define PVCA_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("pvca forbidden condition seen");
`else
`define PVCA_ASSERT(lbl, clk, rstn, prop)
`define PVCA_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ===== hdl/pvca_pkg.sv =====
package pvca_pkg;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_e;

  // Operation codes carried on the input kind field.
  localparam logic [2:0] KIND_ALLOC       = 3'd0;
  localparam logic [2:0] KIND_ALLOC_FORCE = 3'd1;
  localparam logic [2:0] KIND_START       = 3'd2;
  localparam logic [2:0] KIND_RELEASE     = 3'd3;
  localparam logic [2:0] KIND_SET_PRIO    = 3'd4;
  localparam logic [2:0] KIND_KILL        = 3'd5;
  localparam logic [2:0] KIND_UPDATE      = 3'd6;

  // Channel run states.
  localparam logic [1:0] RUN_INACTIVE = 2'd0;
  localparam logic [1:0] RUN_ACTIVE   = 2'd1;
  localparam logic [1:0] RUN_DROP     = 2'd2;

  // Priority encodings.
  localparam logic [8:0] PRIO_FREE      = 9'h1ff;
  localparam logic [8:0] PRIO_SCAN_INIT = 9'h0ff;
  localparam logic [8:0] PRIO_KILL_MAX  = 9'h07f;

  // Owner notices.
  localparam logic [3:0] EV_DROP  = 4'b0001;
  localparam logic [3:0] EV_START = 4'b0010;
  localparam logic [3:0] EV_PLAY  = 4'b0100;
  localparam logic [3:0] EV_STOP  = 4'b1000;

  // DSP commands.
  localparam logic [5:0] CMD_INIT         = 6'b000001;
  localparam logic [5:0] CMD_PLAY_START   = 6'b000010;
  localparam logic [5:0] CMD_PLAY_STOP    = 6'b000100;
  localparam logic [5:0] CMD_FORCE_STOP   = 6'b001000;
  localparam logic [5:0] CMD_REPLY_FINISH = 6'b010000;
  localparam logic [5:0] CMD_FLUSH        = 6'b100000;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;

endpackage

// ===== hdl/priority_voice_channel_allocator.sv =====
// Priority voice channel allocator. The block holds a table of CHANNELS sound
// channels, each with a priority (free or 0..255), a run state, start and
// stop-pending marks, an owner mark and a wrapping play age, in a table memory
// with one write port and one registered read port, read one entry per cycle.
// Every input word produces exactly
// one output word. Alloc (normal and forced) grants the first free channel,
// or else steals the lowest-priority channel at or below the request, with
// ties going to the older channel; kill drops the lowest-priority active
// channel below 0x7f. Both walk the table through one shared compare unit,
// one entry per cycle (alloc stops at the first free entry). Start,
// release owner, set priority and update touch one entry with a read and
// a write. The block takes one word at a time: s_axis_tready_o is high
// only while idle, and a finished result waits in the output register
// until it is taken. Each entry has a valid flop that reset clears, so
// the table is usable straight after reset with no clearing pass. An
// out-of-range channel index on a start, release, set-priority or update
// word, or an unused kind, yields an all-zero result and changes nothing.

`include "priority_voice_channel_allocator_assert.svh"

module priority_voice_channel_allocator #(
  parameter int unsigned CHANNELS = 64,
  parameter int unsigned AGE_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input words.
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // kind[2:0]
  input  logic [2:0]                         s_axis_tuser_i,
  // channel[5:0], priority_req[13:6], owner_given[14], finished[15],
  // owner_accepts[16], owner_keeps[17], zero[23:18]
  input  logic [pvca_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // Result words.
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // found[0], chosen_channel[6:1], owner_events[10:7], dsp_commands[16:11],
  // status_after[18:17], zero[23:19]
  output logic [pvca_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

  typedef struct packed {
    logic [8:0]          prio;
    logic [1:0]          run;
    logic                start;
    logic                stop;
    logic                owner;
    logic [AGE_BITS-1:0] age;
  } rec_t;

  localparam rec_t RESET_REC = '{
    prio:  pvca_pkg::PRIO_FREE,
    run:   pvca_pkg::RUN_INACTIVE,
    start: 1'b0,
    stop:  1'b0,
    owner: 1'b0,
    age:   '0
  };

  // Drop a channel: the owner loses it and an active voice is stopped.
  function automatic rec_t drop_rec(input rec_t r);
    rec_t n;
    n       = r;
    n.owner = 1'b0;
    n.prio  = pvca_pkg::PRIO_FREE;
    n.start = 1'b0;
    if (r.run == pvca_pkg::RUN_ACTIVE) begin
      n.stop = 1'b1;
      n.run  = pvca_pkg::RUN_DROP;
    end
    return n;
  endfunction

  // Input field views.
  logic [2:0]       in_kind;
  logic [5:0]       in_channel;
  logic [7:0]       in_req;
  logic             in_scan;

  assign in_kind    = s_axis_tuser_i;
  assign in_channel = s_axis_tdata_i[5:0];
  assign in_req     = s_axis_tdata_i[13:6];
  assign in_scan    = (in_kind == pvca_pkg::KIND_ALLOC) ||
                      (in_kind == pvca_pkg::KIND_ALLOC_FORCE) ||
                      (in_kind == pvca_pkg::KIND_KILL);

  // Control state.
  pvca_pkg::state_e state_q, state_d;
  logic             m_valid_q;
  logic [CHANNELS-1:0] valid_q;

  // Captured input word.
  logic [2:0]       kind_q;
  logic [IDX_W-1:0] ch_idx_q;
  logic             ch_ok_q;
  logic [7:0]       req_q;
  logic             owner_given_q;
  logic             finished_q;
  logic             accepts_q;
  logic             keeps_q;

  // Scan state.
  logic [IDX_W:0]      scan_idx_q;
  logic [IDX_W-1:0]    cmp_idx_q;
  logic                best_vld_q;
  logic [IDX_W-1:0]    best_idx_q;
  logic [8:0]          best_p_q;
  logic [AGE_BITS-1:0] best_age_q;
  rec_t                best_rec_q;

  // Table memory.
  rec_t             mem [CHANNELS];
  rec_t             rdata_q;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] wr_addr;
  rec_t             rd_rec;

  logic [pvca_pkg::OUT_DATA_W-1:0] out_data_q;

  logic accept_in;
  logic out_free;
  logic load_out;

  assign accept_in = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !m_valid_q || m_axis_tready_i;
  assign rd_rec    = rd_vld_q ? rdata_q : RESET_REC;

  // Scan kind decode for the captured word.
  logic is_alloc;
  logic is_scan;
  assign is_alloc = (kind_q == pvca_pkg::KIND_ALLOC) ||
                    (kind_q == pvca_pkg::KIND_ALLOC_FORCE);
  assign is_scan  = is_alloc || (kind_q == pvca_pkg::KIND_KILL);

  // Shared compare unit: judges the entry that arrives from the table.
  logic signed [9:0] cur_p;
  logic signed [9:0] best_p;
  logic signed [9:0] req_p;
  logic              cur_free;
  logic              cur_ok;
  logic              cur_take;
  logic              scan_last;
  logic              scan_done;

  assign cur_p  = $signed({rd_rec.prio[8], rd_rec.prio});
  assign best_p = $signed({best_p_q[8], best_p_q});
  assign req_p  = $signed({2'b00, req_q});

  always_comb begin
    cur_free = is_alloc && (cur_p < 10'sd0);
    if (is_alloc) begin
      cur_ok = (cur_p <= req_p) && (cur_p <= best_p);
    end else begin
      cur_ok = (rd_rec.run == pvca_pkg::RUN_ACTIVE) &&
               (cur_p < $signed({1'b0, pvca_pkg::PRIO_KILL_MAX})) &&
               (cur_p <= best_p);
    end
    cur_take = cur_ok && ((cur_p != best_p) || (rd_rec.age > best_age_q));
  end

  assign scan_last = (cmp_idx_q == LAST_IDX);
  assign scan_done = cur_free || scan_last;

  // Operation unit: computes the new entry and the result word.
  rec_t       op_rec;
  rec_t       new_rec;
  logic       res_found;
  logic [3:0] res_ev;
  logic [5:0] res_cmd;
  logic [1:0] res_status;
  logic       res_we;

  assign op_rec  = is_scan ? best_rec_q : rd_rec;
  assign wr_addr = is_scan ? best_idx_q : ch_idx_q;

  always_comb begin
    rec_t base;
    logic keep;
    base       = op_rec;
    new_rec    = op_rec;
    res_found  = 1'b0;
    res_ev     = '0;
    res_cmd    = '0;
    res_status = pvca_pkg::RUN_INACTIVE;
    res_we     = 1'b0;
    keep       = 1'b0;
    case (kind_q) inside
      pvca_pkg::KIND_ALLOC, pvca_pkg::KIND_ALLOC_FORCE: begin
        if (best_vld_q) begin
          if (kind_q == pvca_pkg::KIND_ALLOC_FORCE) begin
            base.run = pvca_pkg::RUN_INACTIVE;
          end
          res_ev        = base.owner ? pvca_pkg::EV_DROP : '0;
          new_rec       = drop_rec(base);
          new_rec.prio  = {1'b0, req_q};
          new_rec.age   = '0;
          new_rec.owner = owner_given_q;
          res_found     = 1'b1;
          res_status    = new_rec.run;
          res_we        = 1'b1;
        end
      end
      pvca_pkg::KIND_KILL: begin
        if (best_vld_q) begin
          res_ev     = base.owner ? pvca_pkg::EV_DROP : '0;
          new_rec    = drop_rec(base);
          res_found  = 1'b1;
          res_status = new_rec.run;
          res_we     = 1'b1;
        end
      end
      pvca_pkg::KIND_START: begin
        if (ch_ok_q) begin
          new_rec.start = 1'b1;
          res_status    = op_rec.run;
          res_we        = 1'b1;
        end
      end
      pvca_pkg::KIND_RELEASE: begin
        if (ch_ok_q) begin
          new_rec.owner = 1'b0;
          res_status    = op_rec.run;
          res_we        = 1'b1;
        end
      end
      pvca_pkg::KIND_SET_PRIO: begin
        if (ch_ok_q) begin
          new_rec.prio = {1'b0, req_q};
          res_status   = op_rec.run;
          res_we       = 1'b1;
        end
      end
      pvca_pkg::KIND_UPDATE: begin
        if (ch_ok_q) begin
          res_we = 1'b1;
          // The stop notice keeps the priority only when an owner asks.
          keep   = op_rec.owner && keeps_q;
          if (finished_q) begin
            new_rec.stop = 1'b0;
            if (op_rec.run == pvca_pkg::RUN_ACTIVE) begin
              res_ev = op_rec.owner ? pvca_pkg::EV_STOP : '0;
              if (!keep) begin
                new_rec.prio = pvca_pkg::PRIO_FREE;
              end
            end
            new_rec.run = pvca_pkg::RUN_INACTIVE;
            res_cmd     = pvca_pkg::CMD_REPLY_FINISH | pvca_pkg::CMD_FLUSH;
          end else if (op_rec.stop) begin
            new_rec.stop = 1'b0;
            res_cmd      = pvca_pkg::CMD_FORCE_STOP | pvca_pkg::CMD_FLUSH;
          end else if (op_rec.run != pvca_pkg::RUN_DROP) begin
            if (op_rec.start && (op_rec.run == pvca_pkg::RUN_INACTIVE)) begin
              new_rec.start = 1'b0;
              res_cmd       = pvca_pkg::CMD_INIT;
              res_ev        = op_rec.owner ? pvca_pkg::EV_START : '0;
              if (op_rec.owner && !accepts_q) begin
                // The owner refused the start; the voice never runs.
                new_rec.run = pvca_pkg::RUN_INACTIVE;
                res_ev      = res_ev | pvca_pkg::EV_STOP;
                if (!keep) begin
                  new_rec.prio = pvca_pkg::PRIO_FREE;
                end
                res_cmd = res_cmd | pvca_pkg::CMD_FLUSH;
              end else begin
                new_rec.run = pvca_pkg::RUN_ACTIVE;
                res_cmd     = res_cmd | pvca_pkg::CMD_PLAY_START |
                              pvca_pkg::CMD_FLUSH;
              end
            end else if (op_rec.run != pvca_pkg::RUN_INACTIVE) begin
              res_ev = op_rec.owner ? pvca_pkg::EV_PLAY : '0;
              if (op_rec.owner && !accepts_q) begin
                new_rec.run = pvca_pkg::RUN_INACTIVE;
                res_ev      = res_ev | pvca_pkg::EV_STOP;
                if (!keep) begin
                  new_rec.prio = pvca_pkg::PRIO_FREE;
                end
                res_cmd = pvca_pkg::CMD_PLAY_STOP | pvca_pkg::CMD_FLUSH;
              end else begin
                new_rec.age = op_rec.age + 1'b1;
                res_cmd     = op_rec.owner ? pvca_pkg::CMD_FLUSH : '0;
              end
            end
          end
          res_status = new_rec.run;
        end
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pvca_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = in_scan ? pvca_pkg::ST_SCAN : pvca_pkg::ST_APPLY;
        end
      end
      pvca_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = pvca_pkg::ST_APPLY;
        end
      end
      pvca_pkg::ST_APPLY: begin
        if (out_free) begin
          state_d = pvca_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pvca_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready_o = 1'b0;
    rd_addr         = '0;
    mem_we          = 1'b0;
    load_out        = 1'b0;
    unique case (state_q)
      pvca_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        rd_addr         = in_scan ? '0 : IDX_W'(in_channel);
      end
      pvca_pkg::ST_SCAN: begin
        rd_addr = scan_idx_q[IDX_W-1:0];
      end
      pvca_pkg::ST_APPLY: begin
        // Keep reading the addressed entry so a stalled result sees it intact.
        rd_addr  = ch_idx_q;
        load_out = out_free;
        mem_we   = out_free && res_we;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pvca_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
      valid_q   <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (mem_we) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  // Word capture, scan bookkeeping and result register.
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      kind_q        <= in_kind;
      ch_idx_q      <= IDX_W'(in_channel);
      ch_ok_q       <= (32'(in_channel) < 32'(CHANNELS));
      req_q         <= in_req;
      owner_given_q <= s_axis_tdata_i[14];
      finished_q    <= s_axis_tdata_i[15];
      accepts_q     <= s_axis_tdata_i[16];
      keeps_q       <= s_axis_tdata_i[17];
      scan_idx_q    <= (IDX_W + 1)'(1);
      cmp_idx_q     <= '0;
      best_vld_q    <= 1'b0;
      best_p_q      <= pvca_pkg::PRIO_SCAN_INIT;
      best_age_q    <= '0;
    end else if (state_q == pvca_pkg::ST_SCAN) begin
      scan_idx_q <= scan_idx_q + 1'b1;
      cmp_idx_q  <= scan_idx_q[IDX_W-1:0];
      if (cur_free || cur_take) begin
        best_vld_q <= 1'b1;
        best_idx_q <= cmp_idx_q;
        best_p_q   <= rd_rec.prio;
        best_age_q <= rd_rec.age;
        best_rec_q <= rd_rec;
      end
    end
    if (load_out) begin
      out_data_q <= {5'b00000, res_status, res_cmd, res_ev,
                     res_found ? 6'(best_idx_q) : 6'b000000, res_found};
    end
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= new_rec;
    end
    rdata_q  <= mem[rd_addr];
    rd_vld_q <= valid_q[rd_addr];
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // An accepted word always leaves idle.
  `PVCA_ASSERT(a_accept_leaves_idle, clk_i, rst_ni,
               accept_in |=> (state_q != pvca_pkg::ST_IDLE))
  // A steal candidate never sits above the requested priority.
  `PVCA_ASSERT_NEVER(a_alloc_best_le_req, clk_i, rst_ni,
                     (state_q == pvca_pkg::ST_APPLY) && is_alloc && best_vld_q &&
                     ($signed({best_p_q[8], best_p_q}) > req_p))
  // Kill only ever picks a channel that is playing.
  `PVCA_ASSERT_NEVER(a_kill_picks_active, clk_i, rst_ni,
                     (state_q == pvca_pkg::ST_APPLY) &&
                     (kind_q == pvca_pkg::KIND_KILL) && best_vld_q &&
                     (best_rec_q.run != pvca_pkg::RUN_ACTIVE))
  // A result appears only as the sequencer finishes an operation.
  `PVCA_ASSERT(a_result_from_apply, clk_i, rst_ni,
               $rose(m_valid_q) |-> ($past(state_q) == pvca_pkg::ST_APPLY))

endmodule
